/* rtl/pip_pkg.sv */
// shared types, constants and helpers for the point-in-polygon tester
package pip_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 16;
    localparam int IDX_BITS     = $clog2(MAX_VERTICES);
    localparam int COUNT_BITS   = $clog2(MAX_VERTICES + 1);
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int PROD_BITS    = 2 * DIFF_BITS;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic [1:0] cmd;
        coord_t     coord_x;
        coord_t     coord_y;
    } request_t;

    typedef struct packed {
        logic inside_res;
        logic status;
    } result_t;

    typedef struct packed {
        logic en;
        coord_t x;
        coord_t y;
    } write_t;

    // query token walking down the cell row
    typedef struct packed {
        logic                  valid;
        coord_t                px;
        coord_t                py;
        coord_t                prev_x;
        coord_t                prev_y;
        logic                  parity;
        logic                  pend;
        logic                  den_pos;
        logic [PROD_BITS-1:0]  lhs;
        logic [PROD_BITS-1:0]  rhs;
    } token_t;

    // fold the pending crossing test of the previous edge into the parity
    function automatic logic resolve(token_t t);
        logic crossed;
        if (t.den_pos)
        begin
            crossed = $signed(t.lhs) < $signed(t.rhs);
        end
        else
        begin
            crossed = $signed(t.lhs) > $signed(t.rhs);
        end
        return t.parity ^ (t.pend & crossed);
    endfunction

endpackage

/* rtl/pip_cell.sv */
// one cell of the vertex row: holds one vertex and tests one edge per token
module pip_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [pip_pkg::IDX_BITS-1:0]    idx,
    input  logic [pip_pkg::COUNT_BITS-1:0]  count,
    input  pip_pkg::write_t                 wr,
    input  pip_pkg::token_t                 tok_in,
    output pip_pkg::token_t                 tok_out
);

    pip_pkg::coord_t x_reg;
    pip_pkg::coord_t y_reg;
    pip_pkg::token_t tok_reg;
    pip_pkg::token_t tok_next;
    logic            valid_reg;

    logic hit;
    logic active;
    logic straddle;
    logic near;
    logic signed [pip_pkg::DIFF_BITS-1:0] dx;
    logic signed [pip_pkg::DIFF_BITS-1:0] den;
    logic signed [pip_pkg::DIFF_BITS-1:0] ex;
    logic signed [pip_pkg::DIFF_BITS-1:0] ey;
    logic signed [pip_pkg::PROD_BITS-1:0] lhs;
    logic signed [pip_pkg::PROD_BITS-1:0] rhs;

    assign hit    = count == pip_pkg::COUNT_BITS'(idx);
    assign active = pip_pkg::COUNT_BITS'(idx) < count;

    always_ff @(posedge clk)
    begin
        if (wr.en && hit)
        begin
            x_reg <= wr.x;
            y_reg <= wr.y;
        end
    end

    // edge runs from this vertex (a) to the one before it (b)
    assign dx  = $signed({1'b0, tok_in.prev_x}) - $signed({1'b0, x_reg});
    assign den = $signed({1'b0, tok_in.prev_y}) - $signed({1'b0, y_reg});
    assign ex  = $signed({1'b0, tok_in.px}) - $signed({1'b0, x_reg});
    assign ey  = $signed({1'b0, tok_in.py}) - $signed({1'b0, y_reg});
    assign lhs = pip_pkg::PROD_BITS'(ey) * pip_pkg::PROD_BITS'(dx);
    assign rhs = pip_pkg::PROD_BITS'(ex) * pip_pkg::PROD_BITS'(den);

    assign straddle = (y_reg < tok_in.py && tok_in.prev_y >= tok_in.py) ||
                      (tok_in.prev_y < tok_in.py && y_reg >= tok_in.py);
    assign near     = (x_reg <= tok_in.px) || (tok_in.prev_x <= tok_in.px);

    always_comb
    begin
        tok_next        = tok_in;
        tok_next.parity = pip_pkg::resolve(tok_in);
        tok_next.pend   = 1'b0;
        if (active)
        begin
            tok_next.pend    = straddle & near;
            tok_next.den_pos = tok_in.prev_y > y_reg;
            tok_next.lhs     = lhs;
            tok_next.rhs     = rhs;
            tok_next.prev_x  = x_reg;
            tok_next.prev_y  = y_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tok_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = valid_reg;
    end

endmodule

/* rtl/point_in_polygon_test.sv */
// top level of the point-in-polygon tester: command control, bounding box, cell row
//
// A request is taken at a clock edge where start is high and busy is low.
// request.cmd selects clear, append vertex or query point; coord_x/coord_y
// carry the vertex or the point. Every request gives exactly one result on
// result, marked by done for one cycle; the receiver cannot stall it.
// Clear, append and unused commands answer in the cycle after the request,
// and so does a query on an empty polygon or outside the bounding box; busy
// stays low and a new request may follow every cycle.
// Any other query sends a token down a row of MAX_VERTICES cells, one cell
// per cycle, each cell testing one polygon edge; the result is registered
// once the token leaves the last cell, and busy is high meanwhile, so no new
// request is taken while a walked query runs. An append to a full store is
// dropped with status 1. Reset empties the polygon and resets the bounding
// box; vertex storage itself is not cleared.
module point_in_polygon_test (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  pip_pkg::request_t  request,
    output logic               done,
    output pip_pkg::result_t   result
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                            state_reg,  state_next;
    logic [pip_pkg::COUNT_BITS-1:0]  count_reg,  count_next;
    pip_pkg::coord_t                 min_x_reg,  min_x_next;
    pip_pkg::coord_t                 max_x_reg,  max_x_next;
    pip_pkg::coord_t                 min_y_reg,  min_y_next;
    pip_pkg::coord_t                 max_y_reg,  max_y_next;
    pip_pkg::coord_t                 last_x_reg, last_x_next;
    pip_pkg::coord_t                 last_y_reg, last_y_next;
    pip_pkg::result_t                res_reg,    res_next;
    logic                            done_reg,   done_next;

    logic                            accept;
    logic                            full;
    logic                            outside;
    logic                            launch;
    pip_pkg::write_t                 wr;
    pip_pkg::token_t                 chain [pip_pkg::MAX_VERTICES+1];
    logic [pip_pkg::MAX_VERTICES-1:0] tok_valid;

    assign busy    = state_reg == ST_RUN;
    assign accept  = start && !busy;
    assign full    = count_reg >= pip_pkg::COUNT_BITS'(pip_pkg::MAX_VERTICES);
    assign outside = request.coord_x < min_x_reg || request.coord_y < min_y_reg ||
                     request.coord_x > max_x_reg || request.coord_y > max_y_reg;
    assign launch  = accept && request.cmd == pip_pkg::CMD_QUERY &&
                     count_reg != '0 && !outside;

    assign wr.en = accept && request.cmd == pip_pkg::CMD_APPEND && !full;
    assign wr.x  = request.coord_x;
    assign wr.y  = request.coord_y;

    // the walk starts with the closing edge: previous vertex is the last one
    always_comb
    begin
        chain[0]         = '0;
        chain[0].valid   = launch;
        chain[0].px      = request.coord_x;
        chain[0].py      = request.coord_y;
        chain[0].prev_x  = last_x_reg;
        chain[0].prev_y  = last_y_reg;
    end

    genvar k;
    generate
        for (k = 0; k < pip_pkg::MAX_VERTICES; k++)
        begin : g_cell
            pip_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .idx     (pip_pkg::IDX_BITS'(k)),
                .count   (count_reg),
                .wr      (wr),
                .tok_in  (chain[k]),
                .tok_out (chain[k+1])
            );
            assign tok_valid[k] = chain[k+1].valid;
        end
    endgenerate

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        min_x_next  = min_x_reg;
        max_x_next  = max_x_reg;
        min_y_next  = min_y_reg;
        max_y_next  = max_y_reg;
        last_x_next = last_x_reg;
        last_y_next = last_y_reg;
        res_next    = '0;
        done_next   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (request.cmd)
                        pip_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                            min_x_next = '1;
                            min_y_next = '1;
                            max_x_next = '0;
                            max_y_next = '0;
                            done_next  = 1'b1;
                        end
                        pip_pkg::CMD_APPEND:
                        begin
                            done_next = 1'b1;
                            if (full)
                            begin
                                res_next.status = 1'b1;
                            end
                            else
                            begin
                                count_next  = count_reg + pip_pkg::COUNT_BITS'(1);
                                last_x_next = request.coord_x;
                                last_y_next = request.coord_y;
                                if (request.coord_x < min_x_reg) min_x_next = request.coord_x;
                                if (request.coord_x > max_x_reg) max_x_next = request.coord_x;
                                if (request.coord_y < min_y_reg) min_y_next = request.coord_y;
                                if (request.coord_y > max_y_reg) max_y_next = request.coord_y;
                            end
                        end
                        pip_pkg::CMD_QUERY:
                        begin
                            if (launch)
                            begin
                                state_next = ST_RUN;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                if (chain[pip_pkg::MAX_VERTICES].valid)
                begin
                    res_next.inside_res = pip_pkg::resolve(chain[pip_pkg::MAX_VERTICES]);
                    done_next           = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            min_x_reg <= '1;
            max_x_reg <= '0;
            min_y_reg <= '1;
            max_y_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            min_x_reg <= min_x_next;
            max_x_reg <= max_x_next;
            min_y_reg <= min_y_next;
            max_y_reg <= max_y_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_x_reg <= last_x_next;
        last_y_reg <= last_y_next;
        res_reg    <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

    a_idle_row_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> $countones(tok_valid) == 0)
        else $error("token in cell row while idle");

    a_run_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> $countones(tok_valid) == 1)
        else $error("walked query does not hold exactly one token");

    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid[pip_pkg::MAX_VERTICES-1] |=> done && !busy)
        else $error("token left the row without a result");

    a_drop_not_inside: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status |-> !result.inside_res)
        else $error("dropped vertex reported inside");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pip_pkg::COUNT_BITS'(pip_pkg::MAX_VERTICES))
        else $error("vertex count beyond store size");

endmodule

/* verif/point_in_polygon_test_tb.sv */
// testbench for the point-in-polygon tester: directed table, random polygons, scoreboard
`timescale 1ns / 100ps

module testbench;

    localparam int WALK_CYCLES = pip_pkg::MAX_VERTICES + 1;
    localparam int ITEM_TARGET = 1450;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        pip_pkg::request_t req;
        bit                known;
        pip_pkg::result_t  res;
    } dir_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    pip_pkg::request_t request;
    logic              done;
    pip_pkg::result_t  result;

    // predictor state
    pip_pkg::coord_t poly_x [pip_pkg::MAX_VERTICES];
    pip_pkg::coord_t poly_y [pip_pkg::MAX_VERTICES];
    int              poly_count;
    pip_pkg::coord_t box_min_x, box_max_x, box_min_y, box_max_y;

    pip_pkg::result_t expected_results [$];
    dir_row_t         dir_rows [$];
    bit               idle_en;
    int               n_sent, n_queries, n_inside, n_dropped, n_errors, n_cycles;

    point_in_polygon_test dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", n_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // result scoreboard
    always @(posedge clk)
    begin
        pip_pkg::result_t exp_res;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no request outstanding: inside_res %0d status %0d",
                       result.inside_res, result.status);
                n_errors++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (result.inside_res !== exp_res.inside_res)
                begin
                    $error("inside_res: expected %0d, got %0d",
                           exp_res.inside_res, result.inside_res);
                    n_errors++;
                end
                if (result.status !== exp_res.status)
                begin
                    $error("status: expected %0d, got %0d", exp_res.status, result.status);
                    n_errors++;
                end
            end
        end
    end

    function automatic void empty_polygon_model();
        poly_count = 0;
        box_min_x  = '1;
        box_min_y  = '1;
        box_max_x  = '0;
        box_max_y  = '0;
    endfunction

    // exact test: crossing of edge a-b with the line y = py lies strictly left of px
    function automatic logic crosses_left(longint ax, longint ay, longint bx, longint by,
                                          longint px, longint py);
        longint den, lhs, rhs;
        den = by - ay;
        lhs = (py - ay) * (bx - ax);
        rhs = (px - ax) * den;
        if (den > 0)
            return lhs < rhs;
        return lhs > rhs;
    endfunction

    function automatic pip_pkg::result_t predict_result(pip_pkg::request_t r);
        pip_pkg::result_t res;
        int               j;
        logic             odd;
        longint           xi, yi, xj, yj, sx, sy;
        res = '0;
        case (r.cmd)
            pip_pkg::CMD_CLEAR:
            begin
                empty_polygon_model();
            end
            pip_pkg::CMD_APPEND:
            begin
                if (poly_count >= pip_pkg::MAX_VERTICES)
                begin
                    res.status = 1'b1;
                    n_dropped++;
                end
                else
                begin
                    poly_x[poly_count] = r.coord_x;
                    poly_y[poly_count] = r.coord_y;
                    poly_count++;
                    if (r.coord_x < box_min_x) box_min_x = r.coord_x;
                    if (r.coord_x > box_max_x) box_max_x = r.coord_x;
                    if (r.coord_y < box_min_y) box_min_y = r.coord_y;
                    if (r.coord_y > box_max_y) box_max_y = r.coord_y;
                end
            end
            pip_pkg::CMD_QUERY:
            begin
                n_queries++;
                odd = 1'b0;
                if (poly_count != 0 && r.coord_x >= box_min_x && r.coord_y >= box_min_y &&
                    r.coord_x <= box_max_x && r.coord_y <= box_max_y)
                begin
                    sx = r.coord_x;
                    sy = r.coord_y;
                    j  = poly_count - 1;
                    for (int i = 0; i < poly_count; i++)
                    begin
                        xi = poly_x[i];
                        yi = poly_y[i];
                        xj = poly_x[j];
                        yj = poly_y[j];
                        if (((yi < sy && yj >= sy) || (yj < sy && yi >= sy)) &&
                            (xi <= sx || xj <= sx))
                        begin
                            if (crosses_left(xi, yi, xj, yj, sx, sy))
                                odd = ~odd;
                        end
                        j = i;
                    end
                end
                res.inside_res = odd;
                n_inside += odd;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    task automatic issue_request(input pip_pkg::request_t r, input bit known,
                                 input pip_pkg::result_t known_res);
        pip_pkg::result_t exp_res;
        while (idle_en && $urandom_range(99) < 38)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        exp_res = predict_result(r);
        expected_results = {expected_results, (known ? known_res : exp_res)};
        n_sent++;
    endtask

    // hold off new requests until every outstanding result is back
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    function automatic pip_pkg::request_t make_req(logic [1:0] cmd, int x, int y);
        pip_pkg::request_t r;
        r.cmd     = cmd;
        r.coord_x = pip_pkg::coord_t'(x);
        r.coord_y = pip_pkg::coord_t'(y);
        return r;
    endfunction

    function automatic dir_row_t row(logic [1:0] cmd, int x, int y, bit known);
        dir_row_t d;
        d.req   = make_req(cmd, x, y);
        d.known = known;
        d.res   = '0;
        return d;
    endfunction

    function automatic void put_row(logic [1:0] cmd, int x, int y, bit known);
        dir_rows = {dir_rows, row(cmd, x, y, known)};
    endfunction

    initial
    begin
        int                span, base_x, base_y, n_vert, n_query, pick, k, qx, qy;
        pip_pkg::request_t r;
        bit                first_poly;

        rst_n   <= 1'b0;
        start   <= 1'b0;
        request <= '0;
        idle_en  = 1'b1;
        empty_polygon_model();

        // directed table: rows marked known carry an all-zero expected result
        put_row(pip_pkg::CMD_QUERY,  1000, 1000, 1);   // empty polygon
        put_row(pip_pkg::CMD_APPEND, 0, 0, 1);
        put_row(pip_pkg::CMD_APPEND, 65535, 0, 1);
        put_row(pip_pkg::CMD_APPEND, 65535, 65535, 1);
        put_row(pip_pkg::CMD_APPEND, 0, 65535, 1);
        put_row(pip_pkg::CMD_QUERY,  32768, 32768, 0);
        put_row(pip_pkg::CMD_QUERY,  0, 0, 0);
        put_row(pip_pkg::CMD_QUERY,  65535, 65535, 0);
        put_row(pip_pkg::CMD_QUERY,  65535, 32768, 0);
        put_row(CMD_UNUSED,          65535, 65535, 1);
        put_row(pip_pkg::CMD_CLEAR,  65535, 65535, 1);
        put_row(pip_pkg::CMD_QUERY,  0, 0, 1);          // empty after clear
        put_row(pip_pkg::CMD_APPEND, 100, 100, 1);
        put_row(pip_pkg::CMD_APPEND, 200, 100, 1);
        put_row(pip_pkg::CMD_APPEND, 150, 200, 1);
        put_row(pip_pkg::CMD_QUERY,  50, 50, 1);        // below box
        put_row(pip_pkg::CMD_QUERY,  150, 150, 0);
        put_row(pip_pkg::CMD_QUERY,  150, 100, 0);      // on the flat edge
        put_row(pip_pkg::CMD_QUERY,  150, 200, 0);      // on a vertex
        put_row(pip_pkg::CMD_QUERY,  201, 150, 1);      // right of box
        put_row(pip_pkg::CMD_QUERY,  120, 150, 0);
        put_row(pip_pkg::CMD_CLEAR,  0, 0, 1);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (dir_rows[i])
            issue_request(dir_rows[i].req, dir_rows[i].known, dir_rows[i].res);

        first_poly = 1'b1;
        while (n_sent < ITEM_TARGET)
        begin
            idle_en = !(n_sent >= 700 && n_sent < 1000);
            if ((n_sent >= 400 && n_sent < 420) || $urandom_range(99) < 5)
                drain_results();

            if (!first_poly && $urandom_range(99) < 8)
            begin
                // noise: any command, any coordinates
                r = make_req(2'($urandom_range(3)), $urandom_range(65535),
                             $urandom_range(65535));
                issue_request(r, 0, '0);
            end
            else
            begin
                pick = $urandom_range(2);
                span = (pick == 0) ? 65535 : (pick == 1) ? 255 : 15;
                base_x = $urandom_range(65535 - span);
                base_y = $urandom_range(65535 - span);
                if (first_poly || $urandom_range(99) < 85)
                    issue_request(make_req(pip_pkg::CMD_CLEAR, $urandom_range(65535),
                                           $urandom_range(65535)), 0, '0);
                pick = $urandom_range(99);
                if (first_poly || pick < 5)
                    n_vert = $urandom_range(pip_pkg::MAX_VERTICES + 6,
                                            pip_pkg::MAX_VERTICES - 4);
                else if (pick < 15)
                    n_vert = $urandom_range(pip_pkg::MAX_VERTICES, 13);
                else
                    n_vert = $urandom_range(12, 3);
                first_poly = 1'b0;
                for (int v = 0; v < n_vert; v++)
                    issue_request(make_req(pip_pkg::CMD_APPEND, base_x + $urandom_range(span),
                                           base_y + $urandom_range(span)), 0, '0);
                n_query = $urandom_range(10, 2);
                for (int q = 0; q < n_query; q++)
                begin
                    pick = $urandom_range(99);
                    k    = (poly_count > 0) ? $urandom_range(poly_count - 1) : 0;
                    qx   = base_x + $urandom_range(span);
                    qy   = base_y + $urandom_range(span);
                    if (poly_count > 0 && pick < 20)
                        qy = poly_y[k];                 // level with a vertex
                    else if (poly_count > 0 && pick < 30)
                    begin
                        qx = poly_x[k];
                        qy = poly_y[k];
                    end
                    else if (pick >= 90)
                    begin
                        qx = $urandom_range(65535);
                        qy = $urandom_range(65535);
                    end
                    issue_request(make_req(pip_pkg::CMD_QUERY, qx, qy), 0, '0);
                end
            end
        end

        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (WALK_CYCLES + 4) @(posedge clk);

        $display("%0d requests sent, %0d queries of which %0d inside", n_sent, n_queries,
                 n_inside);
        $display("%0d appends dropped on a full store, %0d mismatches", n_dropped, n_errors);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* point_in_polygon_test.f */
rtl/pip_pkg.sv
rtl/pip_cell.sv
rtl/point_in_polygon_test.sv
verif/point_in_polygon_test_tb.sv
